// ===== src/rdx_pkg.sv =====
// Shared types, constants and helpers for the radix integer-to-digits unit.
// No dependencies; imported by every module of the block.
package rdx_pkg;

   localparam int MaxBase      = 16;
   localparam int MaxDigits    = 32;
   localparam int NumberWidth  = 32;
   localparam int CharWidth    = 8;
   localparam int DigitWidth   = 4;
   localparam int LenWidth     = 5;
   localparam int CountWidth   = 6;
   localparam int BufAddrWidth = 5;

   localparam logic [CharWidth-1:0] MinusSign = 8'h2D;
   localparam logic [CharWidth-1:0] PlusSign  = 8'h2B;

   typedef enum logic [1:0] {
      CSR_BASE_LENGTH  = 2'd0,
      CSR_SYMBOLS_LOW  = 2'd1,
      CSR_SYMBOLS_HIGH = 2'd2
   } csr_index_type;

   typedef logic [MaxBase*CharWidth-1:0] alphabet_type;

   function automatic logic [CharWidth-1:0] symbol_at(input alphabet_type symbols,
                                                      input logic [DigitWidth-1:0] idx);
      return symbols[idx*CharWidth +: CharWidth];
   endfunction

   function automatic logic symbol_forbidden(input logic [CharWidth-1:0] c);
      return (c == 8'h00) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
             (c == 8'h0D) || (c == 8'h20) || (c == 8'h0C) ||
             (c == PlusSign) || (c == MinusSign);
   endfunction

endpackage

// ===== src/rdx_alpha_check.sv =====
// Alphabet validity check: length range, forbidden bytes and repeated symbols.
// Depends on rdx_pkg.
module rdx_alpha_check
   import rdx_pkg::*;
(
   input  logic [LenWidth-1:0] base_length,
   input  alphabet_type        symbols,
   output logic                alphabet_ok
);

   logic bad;

   always_comb begin
      bad = (base_length < LenWidth'(2)) || (base_length > LenWidth'(MaxBase));
      for (int i = 0; i < MaxBase; i++) begin
         if (LenWidth'(i) < base_length) begin
            if (symbol_forbidden(symbol_at(symbols, DigitWidth'(i)))) begin
               bad = 1'b1;
            end
            for (int j = i + 1; j < MaxBase; j++) begin
               if ((LenWidth'(j) < base_length) &&
                   (symbol_at(symbols, DigitWidth'(i)) ==
                    symbol_at(symbols, DigitWidth'(j)))) begin
                  bad = 1'b1;
               end
            end
         end
      end
      alphabet_ok = !bad;
   end

endmodule

// ===== src/rdx_divider.sv =====
// Shared iterative divider: a 32-bit value by a radix of 2 to 16, eight
// quotient bits per cycle. Depends on rdx_pkg.
module rdx_divider
   import rdx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NumberWidth-1:0] dividend,
   input  logic [LenWidth-1:0]    radix,
   output logic                   done,
   output logic [NumberWidth-1:0] quotient,
   output logic [DigitWidth-1:0]  remainder
);

   localparam int BitsPerCycle = 8;
   localparam int Passes       = NumberWidth / BitsPerCycle;
   localparam int PassWidth    = $clog2(Passes);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [PassWidth-1:0]   pass_ff, pass_in;
   logic [NumberWidth-1:0] quo_ff, quo_in;
   logic [DigitWidth-1:0]  rem_ff, rem_in;
   logic [NumberWidth-1:0] q_step;
   logic [DigitWidth-1:0]  r_step;
   logic [LenWidth-1:0]    trial;

   always_comb begin
      q_step = quo_ff;
      r_step = rem_ff;
      trial  = '0;
      for (int i = 0; i < BitsPerCycle; i++) begin
         trial  = {r_step, q_step[NumberWidth-1]};
         q_step = {q_step[NumberWidth-2:0], 1'b0};
         if (trial >= radix) begin
            trial     = trial - radix;
            q_step[0] = 1'b1;
         end
         r_step = trial[DigitWidth-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      pass_in = pass_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         pass_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = q_step;
         rem_in  = r_step;
         pass_in = pass_ff + PassWidth'(1);
         if (pass_ff == PassWidth'(Passes - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pass_ff <= pass_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/radix_integer_to_digits_unit.sv =====
// Radix integer-to-digits unit: converts a signed 32-bit number to its
// characters in a configured alphabet, most significant digit first.
// Each digit takes four divider passes, then a step to store it and restart the divider.
// The next number is taken only after the last character has gone into the output
// register, so output stalls delay it; a number taken under an invalid alphabet
// is dropped and gives no characters.
// Synchronous reset restores the alphabet "0123456789" and clears the control state.
module radix_integer_to_digits_unit
   import rdx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [NumberWidth-1:0] req_tdata,   // number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CharWidth-1:0]   rsp_tdata,   // character
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [LenWidth-1:0]    base_length_ff;
   alphabet_type           symbols_ff;
   logic                   sign_ff, sign_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CharWidth-1:0]   out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;
   logic [DigitWidth-1:0]  digit_buf [MaxDigits];
   logic [BufAddrWidth-1:0] rd_addr;
   logic                   alphabet_ok;
   logic                   accept;
   logic                   div_start;
   logic                   div_done;
   logic [NumberWidth-1:0] div_dividend;
   logic [NumberWidth-1:0] div_quotient;
   logic [DigitWidth-1:0]  div_remainder;
   logic [NumberWidth-1:0] magnitude;
   logic                   out_free;
   logic                   more_digits;

   rdx_alpha_check u_check (
      .base_length (base_length_ff),
      .symbols     (symbols_ff),
      .alphabet_ok (alphabet_ok)
   );

   rdx_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (base_length_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign magnitude   = req_tdata[NumberWidth-1] ? (~req_tdata + NumberWidth'(1)) : req_tdata;
   assign more_digits = (div_quotient != '0) && (count_ff < CountWidth'(MaxDigits - 1));
   assign div_start   = (accept && alphabet_ok) ||
                        ((state_ff == S_DIV) && div_done && more_digits);
   assign div_dividend = (state_ff == S_IDLE) ? magnitude : div_quotient;
   assign out_free    = !out_valid_ff || rsp_tready;
   assign rd_addr     = BufAddrWidth'(count_ff - CountWidth'(1));

   always_comb begin
      state_in     = state_ff;
      sign_in      = sign_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && alphabet_ok) begin
               sign_in  = req_tdata[NumberWidth-1];
               count_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               count_in = count_ff + CountWidth'(1);
               if (!more_digits) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (sign_ff) begin
                  out_char_in = MinusSign;
                  out_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  out_char_in = symbol_at(symbols_ff, digit_buf[rd_addr]);
                  out_last_in = (count_ff == CountWidth'(1));
                  count_in    = count_ff - CountWidth'(1);
                  if (count_ff == CountWidth'(1)) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sign_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DIV) && div_done) begin
         digit_buf[count_ff[BufAddrWidth-1:0]] <= div_remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= LenWidth'(10);
         symbols_ff     <= {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_LENGTH:  base_length_ff <= csr_wdata[LenWidth-1:0];
            CSR_SYMBOLS_LOW:  symbols_ff[63:0] <= csr_wdata;
            CSR_SYMBOLS_HIGH: symbols_ff[127:64] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for radix_integer_to_digits_unit: drives numbers under
// directed and random alphabets and checks every character against a predictor.
// Depends on rdx_pkg and the unit's RTL only.
module tb;
   import rdx_pkg::*;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } char_result_type;

   localparam int ClockPeriod   = 10;
   localparam int ResetCycles   = 7;
   localparam int DrainCycles   = 200;
   localparam int HoldOffCycles = 400;
   localparam int TimeoutCycles = 1_000_000;
   localparam int ItemTarget    = 460;

   localparam logic [1:0] CsrUnused = 2'd3;

   localparam logic [NumberWidth-1:0] MostNegative = 32'h8000_0000;
   localparam logic [NumberWidth-1:0] MostPositive = 32'h7FFF_FFFF;
   localparam logic [NumberWidth-1:0] MinusOne     = 32'hFFFF_FFFF;

   localparam logic [63:0] DecimalLow  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] DecimalHigh = 64'h0000_0000_0000_3938;
   localparam logic [63:0] HexLow      = 64'h3736_3534_3332_3130;
   localparam logic [63:0] HexHigh     = 64'h4645_4443_4241_3938;

   localparam logic [CharWidth-1:0] ReservedBytes [9] = '{
      8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, PlusSign, MinusSign
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [NumberWidth-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CharWidth-1:0]   rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [1:0]             csr_index  = '0;
   logic [63:0]            csr_wdata  = '0;

   radix_integer_to_digits_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   logic [LenWidth-1:0] cfg_length  = 5'd10;
   alphabet_type        cfg_symbols = {DecimalHigh, DecimalLow};

   logic [NumberWidth-1:0] pending_numbers [$];
   char_result_type        expected_chars [$];

   int unsigned numbers_issued   = 0;
   int unsigned numbers_accepted = 0;
   int unsigned valid_numbers    = 0;
   int unsigned chars_checked    = 0;
   int unsigned error_count      = 0;
   int unsigned random_phases    = 0;

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_hold = 0;
   int unsigned req_gap_max = 3;
   int unsigned rsp_gap_max = 3;
   logic        rsp_hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic logic is_reserved(input logic [CharWidth-1:0] c);
      for (int i = 0; i < 9; i++)
         if (c == ReservedBytes[i])
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic alphabet_ok(input logic [LenWidth-1:0] length,
                                        input alphabet_type symbols);
      logic [CharWidth-1:0] c;
      if (length < 2 || length > MaxBase)
         return 1'b0;
      for (int i = 0; i < length; i++) begin
         c = symbols[i*CharWidth +: CharWidth];
         if (is_reserved(c))
            return 1'b0;
         for (int j = i + 1; j < length; j++)
            if (symbols[j*CharWidth +: CharWidth] == c)
               return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_conversion(input logic [NumberWidth-1:0] number);
      logic [NumberWidth-1:0] magnitude;
      logic [NumberWidth-1:0] radix;
      logic [DigitWidth-1:0]  digits [MaxDigits];
      int unsigned            count;
      if (!alphabet_ok(cfg_length, cfg_symbols))
         return;
      radix = NumberWidth'(cfg_length);
      magnitude = number[NumberWidth-1] ? -number : number;
      count = 0;
      do begin
         digits[count] = DigitWidth'(magnitude % radix);
         magnitude = magnitude / radix;
         count++;
      end while (magnitude != 0);
      if (number[NumberWidth-1])
         expected_chars.push_back('{MinusSign, 1'b0});
      for (int k = count; k > 0; k--)
         expected_chars.push_back('{cfg_symbols[digits[k-1]*CharWidth +: CharWidth], k == 1});
   endfunction

   function automatic logic [NumberWidth-1:0] draw_number();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 300);
         1: return -$urandom_range(1, 300);
         2: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return MostNegative;
               2: return MostPositive;
               3: return MinusOne;
               default: return 32'd1;
            endcase
         end
         3: return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic alphabet_type draw_alphabet(input int unsigned count);
      alphabet_type         symbols;
      logic [CharWidth-1:0] c;
      logic                 clash;
      symbols = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < count; i++) begin
         forever begin
            c = CharWidth'($urandom_range(0, 255));
            clash = is_reserved(c);
            for (int j = 0; j < i; j++)
               if (symbols[j*CharWidth +: CharWidth] == c)
                  clash = 1'b1;
            if (!clash)
               break;
         end
         symbols[i*CharWidth +: CharWidth] = c;
      end
      return symbols;
   endfunction

   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_BASE_LENGTH:  cfg_length = value[LenWidth-1:0];
         CSR_SYMBOLS_LOW:  cfg_symbols[63:0] = value;
         CSR_SYMBOLS_HIGH: cfg_symbols[127:64] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_length(input int unsigned length);
      logic [63:0] value;
      value = {$urandom, $urandom};
      value[LenWidth-1:0] = LenWidth'(length);
      write_register(CSR_BASE_LENGTH, value);
   endtask

   task automatic send_number(input logic [NumberWidth-1:0] number);
      pending_numbers.push_back(number);
      numbers_issued++;
      if (alphabet_ok(cfg_length, cfg_symbols))
         valid_numbers++;
   endtask

   task automatic wait_idle();
      while (pending_numbers.size() != 0 || numbers_accepted != numbers_issued ||
             expected_chars.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic apply_random_alphabet();
      int unsigned  length;
      int unsigned  pos;
      alphabet_type symbols;
      case ($urandom_range(0, 3))
         0: length = 2;
         1: length = MaxBase;
         default: length = $urandom_range(2, MaxBase);
      endcase
      symbols = draw_alphabet(length);
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0: length = $urandom_range(0, 1);
            1: length = $urandom_range(MaxBase + 1, 31);
            2: symbols[$urandom_range(0, length - 1)*CharWidth +: CharWidth] =
                  ReservedBytes[$urandom_range(0, 8)];
            default: begin
               pos = $urandom_range(1, length - 1);
               symbols[pos*CharWidth +: CharWidth] =
                  symbols[$urandom_range(0, pos - 1)*CharWidth +: CharWidth];
            end
         endcase
      end
      write_length(length);
      write_register(CSR_SYMBOLS_LOW, symbols[63:0]);
      write_register(CSR_SYMBOLS_HIGH, symbols[127:64]);
      if ($urandom_range(0, 5) == 0)
         write_register(CsrUnused, {$urandom, $urandom});
   endtask

   always @(negedge clock) begin : number_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid && !req_taken;
         if (!offer) begin
            if (req_taken)
               req_wait = $urandom_range(0, req_gap_max);
            if (req_wait != 0) begin
               req_wait--;
            end else if (pending_numbers.size() != 0) begin
               req_tdata <= pending_numbers.pop_front();
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   always @(negedge clock) begin : char_receiver
      logic accept;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_hold_request) begin
            rsp_hold = HoldOffCycles;
            rsp_hold_request = 1'b0;
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            accept = 1'b0;
         end else begin
            if (rsp_taken)
               rsp_wait = $urandom_range(0, rsp_gap_max);
            if (rsp_wait != 0) begin
               rsp_wait--;
               accept = 1'b0;
            end else begin
               accept = 1'b1;
            end
         end
         rsp_tready <= accept;
      end
   end

   always @(posedge clock) begin : transfer_monitor
      char_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            predict_conversion(req_tdata);
            numbers_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none, actual %h (last %b)",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.character) begin
                  $display("%0t: character mismatch, expected %h, actual %h",
                           $time, want.character, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last flag mismatch, expected %b, actual %b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int unsigned count;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Alphabet left by reset.
      send_number('0);
      send_number(32'd1);
      send_number(MinusOne);
      send_number(32'd9);
      send_number(32'd10);
      send_number(-32'd10);
      send_number(32'd1234567890);
      send_number(MostPositive);
      send_number(MostNegative);
      send_number(MostNegative + 32'd1);
      wait_idle();

      write_length(2);
      write_register(CSR_SYMBOLS_LOW, {$urandom, 16'($urandom), 16'h3130});
      send_number(MostNegative);
      send_number(MinusOne);
      send_number(MostPositive);
      send_number('0);
      wait_idle();

      write_length(MaxBase);
      write_register(CSR_SYMBOLS_LOW, HexLow);
      write_register(CSR_SYMBOLS_HIGH, HexHigh);
      send_number(MostPositive);
      send_number(32'h0000_000F);
      wait_idle();
      write_register(CsrUnused, '1);
      send_number(32'hDEAD_BEEF);
      wait_idle();

      write_length(0);
      send_number(32'd5);
      wait_idle();
      write_length(1);
      send_number(32'd5);
      wait_idle();
      write_length(31);
      send_number(32'd5);
      wait_idle();
      write_length(MaxBase);
      write_register(CSR_SYMBOLS_HIGH, '0);
      send_number(32'd5);
      wait_idle();
      write_register(CSR_SYMBOLS_HIGH, '1);
      send_number(32'd5);
      wait_idle();
      write_register(CSR_SYMBOLS_HIGH, HexHigh);
      write_register(CSR_SYMBOLS_LOW, {HexLow[63:32], 8'h20, HexLow[23:0]});
      send_number(32'd5);
      wait_idle();
      write_register(CSR_SYMBOLS_LOW, {PlusSign, HexLow[55:0]});
      send_number(32'd5);
      wait_idle();
      write_register(CSR_SYMBOLS_LOW, {HexLow[63:8], MinusSign});
      send_number(32'd5);
      wait_idle();

      while (numbers_issued < ItemTarget) begin
         apply_random_alphabet();
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
         rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
         count = alphabet_ok(cfg_length, cfg_symbols) ? $urandom_range(20, 36) : 4;
         repeat (count) send_number(draw_number());
         if (random_phases == 0 || $urandom_range(0, 7) == 0)
            rsp_hold_request = 1'b1;
         wait_idle();
         random_phases++;
      end

      $display("Accepted %0d numbers (%0d dropped under invalid alphabets), checked %0d characters.",
               numbers_accepted, numbers_issued - valid_numbers, chars_checked);
      $display("Ran %0d random alphabet phases after the directed cases.", random_phases);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(TimeoutCycles * ClockPeriod);
      $display("%0t: timed out with %0d characters still expected", $time,
               expected_chars.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
src/rdx_pkg.sv
src/rdx_alpha_check.sv
src/rdx_divider.sv
src/radix_integer_to_digits_unit.sv
tb/tb.sv
